// ===== src/hrd_pkg.sv =====
// Package for the HTTP response deframer: phase codes, result codes and the
// transaction record passed from front to back. No dependencies.
package hrd_pkg;
   localparam int LENGTH_BITS = 32;
   localparam int QDEPTH = 2;

   typedef enum logic [3:0] {
      PH_STATUS, PH_HNAME, PH_HVAL_CL, PH_HVAL_TE, PH_HVAL_OTHER, PH_BODY, PH_CSIZE,
      PH_CEXT, PH_CDATA, PH_CCR, PH_CLF, PH_TRAILER, PH_HALT
   } phase_type;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_CHUNK = 3'd1;
   localparam logic [2:0] ERR_CLEN = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_STATUS = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] body_byte;
      logic       response_end;
      logic [9:0] status_code;
      logic       was_chunked;
      logic [2:0] error_code;
   } result_type;

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: cl_char = "C"; 5'd1: cl_char = "o"; 5'd2: cl_char = "n"; 5'd3: cl_char = "t";
         5'd4: cl_char = "e"; 5'd5: cl_char = "n"; 5'd6: cl_char = "t"; 5'd7: cl_char = "-";
         5'd8: cl_char = "L"; 5'd9: cl_char = "e"; 5'd10: cl_char = "n"; 5'd11: cl_char = "g";
         5'd12: cl_char = "t"; 5'd13: cl_char = "h";
         default: cl_char = 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: te_char = "T"; 5'd1: te_char = "r"; 5'd2: te_char = "a"; 5'd3: te_char = "n";
         5'd4: te_char = "s"; 5'd5: te_char = "f"; 5'd6: te_char = "e"; 5'd7: te_char = "r";
         5'd8: te_char = "-"; 5'd9: te_char = "E"; 5'd10: te_char = "n"; 5'd11: te_char = "c";
         5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i"; 5'd15: te_char = "n";
         5'd16: te_char = "g";
         default: te_char = 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] tw_char(input logic [4:0] i);
      case (i)
         5'd0: tw_char = "c"; 5'd1: tw_char = "h"; 5'd2: tw_char = "u"; 5'd3: tw_char = "n";
         5'd4: tw_char = "k"; 5'd5: tw_char = "e"; 5'd6: tw_char = "d";
         default: tw_char = 8'd0;
      endcase
   endfunction
endpackage

// ===== src/hrd_front.sv =====
// Front end: accepts bytes, runs the parser state and produces one optional
// result per byte. Depends on hrd_pkg.
module hrd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic                new_connection,
   output logic                res_valid,
   output hrd_pkg::result_type res
);
   import hrd_pkg::*;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] DEC_LIM = LEN_MAX / 10;
   localparam logic [3:0] DEC_REM = 4'(LEN_MAX % 10);
   localparam logic [LENGTH_BITS-1:0] HEX_LIM = LEN_MAX >> 4;

   phase_type phase_ff, phase_in;
   logic [9:0] code_ff, code_in;
   logic [1:0] space_ff, space_in;
   logic cr_ff, cr_in;
   logic [4:0] pos_ff, pos_in;
   logic [1:0] name_ff, name_in;
   logic [2:0] vm_ff, vm_in;
   logic [LENGTH_BITS-1:0] decl_ff, decl_in, rem_ff, rem_in;
   logic chunk_ff, chunk_in;
   logic dig_ff, dig_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; code_ff <= '0; space_ff <= '0; cr_ff <= 1'b0;
         pos_ff <= '0; name_ff <= 2'b11; vm_ff <= '0; decl_ff <= '0; rem_ff <= '0;
         chunk_ff <= 1'b0; dig_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; code_ff <= code_in; space_ff <= space_in; cr_ff <= cr_in;
         pos_ff <= pos_in; name_ff <= name_in; vm_ff <= vm_in; decl_ff <= decl_in;
         rem_ff <= rem_in; chunk_ff <= chunk_in; dig_ff <= dig_in;
      end
   end

   always_comb begin
      logic [7:0] c;
      logic [3:0] hv;
      logic is_hex, is_dig, blank, fin, fin_line, do_char, stop;
      logic [9:0] cv;
      logic [LENGTH_BITS-1:0] dec;
      logic [1:0] st;
      phase_type ph;
      logic [9:0] code0;
      logic [1:0] sp0, nm0;
      logic [4:0] pos0;
      logic [2:0] vm0;
      logic [LENGTH_BITS-1:0] decl0, rem0;
      logic chk0, dig0;

      if (new_connection) begin
         ph = PH_STATUS; code0 = '0; sp0 = '0; pos0 = '0; nm0 = 2'b11; vm0 = '0;
         decl0 = '0; rem0 = '0; chk0 = 1'b0; dig0 = 1'b0; cr_in = 1'b0;
      end else begin
         ph = phase_ff; code0 = code_ff; sp0 = space_ff; pos0 = pos_ff; nm0 = name_ff;
         vm0 = vm_ff; decl0 = decl_ff; rem0 = rem_ff; chk0 = chunk_ff; dig0 = dig_ff;
         cr_in = cr_ff;
      end
      phase_in = ph; code_in = code0; space_in = sp0; pos_in = pos0; name_in = nm0;
      vm_in = vm0; decl_in = decl0; rem_in = rem0; chunk_in = chk0; dig_in = dig0;

      res_valid = 1'b0;
      res.kind = KIND_BYTE;
      res.body_byte = 8'd0;
      res.response_end = 1'b0;
      res.error_code = ERR_NONE;
      fin = 1'b0;
      fin_line = 1'b0;
      do_char = 1'b0;
      stop = 1'b0;
      c = rx_byte;
      hv = 4'd0;
      dec = rem0 - 1'b1;

      case (ph)
         PH_HALT: stop = 1'b1;
         PH_BODY: begin
            stop = 1'b1;
            rem_in = dec;
            res_valid = 1'b1;
            res.body_byte = rx_byte;
            if (dec == '0) begin
               res.response_end = 1'b1;
               fin = 1'b1;
            end
         end
         PH_CDATA: begin
            stop = 1'b1;
            rem_in = dec;
            if (dec == '0) phase_in = PH_CCR;
            res_valid = 1'b1;
            res.body_byte = rx_byte;
         end
         PH_CCR: begin
            stop = 1'b1;
            if (rx_byte != 8'h0d) begin
               res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CHUNK;
            end else phase_in = PH_CLF;
         end
         PH_CLF: begin
            stop = 1'b1;
            if (rx_byte != 8'h0a) begin
               res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CHUNK;
            end else begin
               phase_in = PH_CSIZE; rem_in = '0; dig_in = 1'b0; vm_in = '0;
            end
         end
         default: ;
      endcase

      if (!stop) begin
         if (cr_in) begin
            cr_in = 1'b0;
            if (rx_byte == 8'h0a) begin
               fin_line = 1'b1;
            end else begin
               // A CR without LF is a line character that comes before this byte.
               case (ph)
                  PH_STATUS: begin
                     if (sp0 == 2'd1) vm0 = vm0 | 3'b001;
                     if (pos0 != 5'd31) pos0 = pos0 + 5'd1;
                  end
                  PH_HNAME: begin
                     nm0 = 2'b00;
                     if (pos0 != 5'd31) pos0 = pos0 + 5'd1;
                  end
                  PH_HVAL_CL: begin
                     res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CLEN;
                  end
                  PH_HVAL_TE: vm0 = (vm0[1:0] == 2'd2) ? 3'b110 : 3'b101;
                  PH_CSIZE: begin
                     res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CHUNK;
                  end
                  PH_TRAILER: pos0 = 5'd1;
                  default: ;
               endcase
               name_in = nm0; vm_in = vm0; pos_in = pos0;
               if (!res_valid) begin
                  if (rx_byte == 8'h0d) cr_in = 1'b1;
                  else do_char = 1'b1;
               end
            end
         end else if (rx_byte == 8'h0d) begin
            cr_in = 1'b1;
         end else begin
            do_char = 1'b1;
         end
      end

      // Line end handling.
      if (fin_line) begin
         case (ph)
            PH_STATUS: begin
               if (sp0 != 2'd2 || !dig0 || vm0[0]) begin
                  res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_STATUS;
               end else begin
                  phase_in = PH_HNAME; pos_in = '0; name_in = 2'b11; vm_in = '0;
                  dig_in = 1'b0; rem_in = '0;
               end
            end
            PH_HNAME: begin
               if (pos0 == '0) begin
                  if (chk0) begin
                     phase_in = PH_CSIZE; rem_in = '0; dig_in = 1'b0; vm_in = '0;
                  end else if (decl0 != '0) begin
                     phase_in = PH_BODY; rem_in = decl0;
                  end else begin
                     res_valid = 1'b1; res.kind = KIND_END; res.response_end = 1'b1;
                     fin = 1'b1;
                  end
               end else begin
                  phase_in = PH_HNAME; pos_in = '0; name_in = 2'b11; vm_in = '0;
                  dig_in = 1'b0; rem_in = '0;
               end
            end
            PH_HVAL_CL: begin
               if (!dig0) begin
                  res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CLEN;
               end else begin
                  decl_in = rem0;
                  phase_in = PH_HNAME; pos_in = '0; name_in = 2'b11; vm_in = '0;
                  dig_in = 1'b0; rem_in = '0;
               end
            end
            PH_HVAL_TE: begin
               if (!vm0[2] && vm0[1:0] != 2'd0 && pos0 == 5'd7)
                  chunk_in = 1'b1;
               phase_in = PH_HNAME; pos_in = '0; name_in = 2'b11; vm_in = '0;
               dig_in = 1'b0; rem_in = '0;
            end
            PH_CSIZE, PH_CEXT: begin
               if (!dig0) begin
                  res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CHUNK;
               end else if (rem0 == '0) begin
                  phase_in = PH_TRAILER; pos_in = '0;
               end else phase_in = PH_CDATA;
            end
            PH_TRAILER: begin
               if (pos0 == '0) begin
                  res_valid = 1'b1; res.kind = KIND_END; res.response_end = 1'b1;
                  fin = 1'b1;
               end else pos_in = '0;
            end
            default: ;
         endcase
      end

      // Ordinary line character.
      is_dig = (c >= "0") && (c <= "9");
      blank = (c == " ") || (c == 8'h09);
      is_hex = 1'b1;
      if (is_dig) hv = 4'(c - "0");
      else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
      else is_hex = 1'b0;
      cv = 10'd0;
      st = vm0[1:0];
      if (do_char) begin
         case (ph)
            PH_STATUS: begin
               if (c == " ") begin
                  if (sp0 != 2'd2) space_in = sp0 + 2'd1;
               end else if (sp0 == 2'd1) begin
                  if (is_dig) begin
                     cv = (code0 << 3) + (code0 << 1);
                     if (code0 >= 10'd100) code_in = 10'd999;
                     else if (cv + 10'(hv) > 10'd999) code_in = 10'd999;
                     else code_in = cv + 10'(hv);
                     dig_in = 1'b1;
                  end else vm_in = vm0 | 3'b001;
               end
               if (pos0 != 5'd31) pos_in = pos0 + 5'd1;
            end
            PH_HNAME: begin
               if (c == ":") begin
                  if (nm0[0] && pos0 == 5'd14) phase_in = PH_HVAL_CL;
                  else if (nm0[1] && pos0 == 5'd17) phase_in = PH_HVAL_TE;
                  else phase_in = PH_HVAL_OTHER;
                  pos_in = '0; vm_in = '0; dig_in = 1'b0; rem_in = '0;
               end else begin
                  if (pos0 >= 5'd14 || cl_char(pos0) != c) name_in[0] = 1'b0;
                  if (pos0 >= 5'd17 || te_char(pos0) != c) name_in[1] = 1'b0;
                  if (pos0 != 5'd31) pos_in = pos0 + 5'd1;
               end
            end
            PH_HVAL_CL: begin
               if (blank) begin
                  if (vm0 == 3'd1) vm_in = 3'd2;
               end else if (is_dig && vm0 != 3'd2) begin
                  if (rem0 > DEC_LIM || (rem0 == DEC_LIM && hv > DEC_REM)) begin
                     res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_OVERFLOW;
                  end else begin
                     rem_in = (rem0 << 3) + (rem0 << 1) + LENGTH_BITS'(hv);
                     vm_in = 3'd1; dig_in = 1'b1;
                  end
               end else begin
                  res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CLEN;
               end
            end
            PH_HVAL_TE: begin
               if (blank) begin
                  if (st == 2'd1) vm_in = {vm0[2], 2'd2};
               end else if (st == 2'd2) begin
                  vm_in = vm0 | 3'b100;
               end else begin
                  if (pos0 < 5'd7 && tw_char(pos0) == c) begin
                     pos_in = pos0 + 5'd1;
                     vm_in = {vm0[2], 2'd1};
                  end else vm_in = 3'b101;
               end
            end
            PH_CSIZE: begin
               if (is_hex && vm0 == 3'd0) begin
                  if (rem0 > HEX_LIM) begin
                     res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_OVERFLOW;
                  end else begin
                     rem_in = {rem0[LENGTH_BITS-5:0], hv}; dig_in = 1'b1;
                  end
               end else if (dig0 && blank) vm_in = 3'd1;
               else if (dig0 && c == ";") phase_in = PH_CEXT;
               else begin
                  res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CHUNK;
               end
            end
            PH_TRAILER: pos_in = 5'd1;
            default: ;
         endcase
      end

      res.status_code = code_in;
      res.was_chunked = chunk_in;
      if (res.kind == KIND_ERROR) begin
         res.response_end = 1'b1;
         phase_in = PH_HALT;
      end
      if (fin) begin
         phase_in = PH_STATUS; code_in = '0; space_in = '0; cr_in = 1'b0; pos_in = '0;
         name_in = 2'b11; vm_in = '0; decl_in = '0; rem_in = '0; chunk_in = 1'b0;
         dig_in = 1'b0;
      end
   end
endmodule

// ===== src/hrd_back.sv =====
// Back end: a two-entry queue of results and the registered output port.
// Depends on hrd_pkg.
module hrd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrd_pkg::result_type push_data,
   output logic                has_room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hrd_pkg::result_type rsp_data
);
   import hrd_pkg::*;

   result_type q_ff [QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic pop;
   logic push_head;

   assign pop = rsp_valid && !rsp_stall;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data = q_ff[0];
   assign has_room = cnt_ff != 2'(QDEPTH);
   assign push_head = push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (push_head) q_ff[0] <= push_data;
      else if (pop) q_ff[0] <= q_ff[1];
      if (push && !push_head) q_ff[1] <= push_data;
   end
endmodule

// ===== src/http_response_deframer_unit.sv =====
// HTTP/1.1 response deframer top level: byte parser front end feeding a
// two-entry result queue. Depends on hrd_pkg, hrd_front and hrd_back.
// Each result is pushed into the registered result queue when its byte is accepted and leaves it on rsp_ in order.
// Throughput: one byte per cycle while the result queue has room.
// Reset: synchronous, active high; the parser returns to the status line
// and the queue empties.
module http_response_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_new_connection,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_body_byte,
   output logic       rsp_response_end,
   output logic [9:0] rsp_status_code,
   output logic       rsp_was_chunked,
   output logic [2:0] rsp_error_code
);
   import hrd_pkg::*;

   logic step, res_valid, has_room;
   result_type res, out_data;

   assign req_stall = !has_room;
   assign step = req_valid && has_room;

   hrd_front u_front (
      .clock, .reset, .step,
      .rx_byte(req_rx_byte), .new_connection(req_new_connection),
      .res_valid, .res
   );

   hrd_back u_back (
      .clock, .reset,
      .push(step && res_valid), .push_data(res), .has_room,
      .rsp_valid, .rsp_stall, .rsp_data(out_data)
   );

   assign rsp_kind = out_data.kind;
   assign rsp_body_byte = out_data.body_byte;
   assign rsp_response_end = out_data.response_end;
   assign rsp_status_code = out_data.status_code;
   assign rsp_was_chunked = out_data.was_chunked;
   assign rsp_error_code = out_data.error_code;
endmodule

// ===== tb/sv/tb_http_response_deframer_unit.sv =====
// Self-checking testbench for http_response_deframer_unit: drives response byte
// streams, predicts each result with a behavioral parser and compares it.
// Depends on hrd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_http_response_deframer_unit;
   import hrd_pkg::*;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       new_conn;
   } byte_item_t;

   localparam logic [63:0] LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       req_new_connection = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_body_byte;
   logic       rsp_response_end;
   logic [9:0] rsp_status_code;
   logic       rsp_was_chunked;
   logic [2:0] rsp_error_code;

   byte_item_t   pending_bytes[$];
   result_type   expected_results[$];
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           error_count = 0;
   longint       cycle_count = 0;

   // Predictor state.
   phase_type   p_phase;
   logic [9:0]  p_code;
   logic [1:0]  p_spaces;
   logic        p_cr;
   logic [4:0]  p_pos;
   logic [1:0]  p_names;
   logic [2:0]  p_vflags;
   logic [63:0] p_declared;
   logic [63:0] p_remaining;
   logic        p_chunked;
   logic        p_digits;

   http_response_deframer_unit dut (.*);

   always #4 clock = ~clock;

   function automatic logic [7:0] str_char(string s, int i);
      return (i < s.len()) ? s[i] : 8'd0;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == " " || c == 8'h09;
   endfunction

   task automatic clear_parser();
      p_phase = PH_STATUS; p_code = 0; p_spaces = 0; p_cr = 0; p_pos = 0;
      p_names = 2'b11; p_vflags = 0; p_declared = 0; p_remaining = 0;
      p_chunked = 0; p_digits = 0;
   endtask

   function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic last,
                                       logic [2:0] err);
      result_type r;
      r.kind = kind; r.body_byte = b; r.response_end = last; r.status_code = p_code;
      r.was_chunked = p_chunked; r.error_code = err;
      expected_results.push_back(r);
   endfunction

   function automatic void raise_error(logic [2:0] err);
      push_result(KIND_ERROR, 8'd0, 1'b1, err);
      p_phase = PH_HALT;
   endfunction

   task automatic end_response(logic [1:0] kind, logic [7:0] b);
      push_result(kind, b, 1'b1, ERR_NONE);
      clear_parser();
   endtask

   function automatic logic parse_line_char(logic [7:0] c);
      int h;
      case (p_phase)
         PH_STATUS: begin
            if (c == " ") begin
               if (p_spaces < 2) p_spaces++;
            end else if (p_spaces == 1) begin
               if (c >= "0" && c <= "9") begin
                  p_code = (p_code * 10 + (c - "0") > 999) ? 10'd999
                                                           : 10'(p_code * 10 + (c - "0"));
                  p_digits = 1;
               end else begin
                  p_vflags[0] = 1;
               end
            end
            if (p_pos < 31) p_pos++;
         end
         PH_HNAME: begin
            if (c == ":") begin
               if (p_names[0] && p_pos == 14) p_phase = PH_HVAL_CL;
               else if (p_names[1] && p_pos == 17) p_phase = PH_HVAL_TE;
               else p_phase = PH_HVAL_OTHER;
               p_pos = 0; p_vflags = 0; p_digits = 0; p_remaining = 0;
               return 0;
            end
            if (p_pos >= 14 || str_char("Content-Length", p_pos) != c) p_names[0] = 0;
            if (p_pos >= 17 || str_char("Transfer-Encoding", p_pos) != c) p_names[1] = 0;
            if (p_pos < 31) p_pos++;
         end
         PH_HVAL_CL: begin
            if (is_blank(c)) begin
               if (p_vflags == 1) p_vflags = 2;
               return 0;
            end
            if (c >= "0" && c <= "9" && p_vflags != 2) begin
               if (p_remaining > (LEN_LIMIT - (c - "0")) / 10) begin
                  raise_error(ERR_OVERFLOW);
                  return 1;
               end
               p_remaining = p_remaining * 10 + (c - "0");
               p_vflags = 1; p_digits = 1;
               return 0;
            end
            raise_error(ERR_CLEN);
            return 1;
         end
         PH_HVAL_TE: begin
            if (is_blank(c)) begin
               if (p_vflags[1:0] == 1) p_vflags = {p_vflags[2], 2'b10};
            end else if (p_vflags[1:0] == 2) begin
               p_vflags[2] = 1;
            end else begin
               if (p_pos < 7 && str_char("chunked", p_pos) == c) p_pos++;
               else p_vflags[2] = 1;
               p_vflags[1:0] = 2'b01;
            end
         end
         PH_CSIZE: begin
            h = hex_digit(c);
            if (h >= 0 && p_vflags == 0) begin
               if (p_remaining > (LEN_LIMIT >> 4)) begin
                  raise_error(ERR_OVERFLOW);
                  return 1;
               end
               p_remaining = (p_remaining << 4) | h;
               p_digits = 1;
               return 0;
            end
            if (p_digits && is_blank(c)) begin
               p_vflags = 1;
               return 0;
            end
            if (p_digits && c == ";") begin
               p_phase = PH_CEXT;
               return 0;
            end
            raise_error(ERR_CHUNK);
            return 1;
         end
         PH_TRAILER: p_pos = 1;
         default: ;
      endcase
      return 0;
   endfunction

   task automatic parse_line_end();
      case (p_phase)
         PH_STATUS: begin
            if (p_spaces < 2 || !p_digits || p_vflags[0]) begin
               raise_error(ERR_STATUS);
               return;
            end
            p_phase = PH_HNAME;
         end
         PH_HNAME:
            if (p_pos == 0) begin
               if (p_chunked) begin
                  p_phase = PH_CSIZE; p_remaining = 0; p_digits = 0; p_vflags = 0;
               end else if (p_declared > 0) begin
                  p_phase = PH_BODY; p_remaining = p_declared;
               end else begin
                  end_response(KIND_END, 8'd0);
               end
               return;
            end
         PH_HVAL_CL: begin
            if (!p_digits) begin
               raise_error(ERR_CLEN);
               return;
            end
            p_declared = p_remaining;
         end
         PH_HVAL_TE:
            if (!p_vflags[2] && p_vflags[1:0] != 0 && p_pos == 7) p_chunked = 1;
         PH_CSIZE, PH_CEXT: begin
            if (!p_digits) raise_error(ERR_CHUNK);
            else if (p_remaining == 0) begin
               p_phase = PH_TRAILER; p_pos = 0;
            end else p_phase = PH_CDATA;
            return;
         end
         PH_TRAILER: begin
            if (p_pos == 0) end_response(KIND_END, 8'd0);
            else p_pos = 0;
            return;
         end
         default: return;
      endcase
      p_phase = PH_HNAME;
      p_pos = 0; p_names = 2'b11; p_vflags = 0; p_digits = 0; p_remaining = 0;
   endtask

   task automatic predict_byte(byte_item_t it);
      logic [7:0] c;
      c = it.rx_byte;
      if (it.new_conn) clear_parser();
      case (p_phase)
         PH_HALT: return;
         PH_BODY: begin
            p_remaining = (p_remaining - 1) & LEN_LIMIT;
            if (p_remaining == 0) end_response(KIND_BYTE, c);
            else push_result(KIND_BYTE, c, 1'b0, ERR_NONE);
            return;
         end
         PH_CDATA: begin
            p_remaining = (p_remaining - 1) & LEN_LIMIT;
            if (p_remaining == 0) p_phase = PH_CCR;
            push_result(KIND_BYTE, c, 1'b0, ERR_NONE);
            return;
         end
         PH_CCR: begin
            if (c != 8'h0d) raise_error(ERR_CHUNK);
            else p_phase = PH_CLF;
            return;
         end
         PH_CLF: begin
            if (c != 8'h0a) raise_error(ERR_CHUNK);
            else begin
               p_phase = PH_CSIZE; p_remaining = 0; p_digits = 0; p_vflags = 0;
            end
            return;
         end
         default: ;
      endcase
      if (p_cr) begin
         p_cr = 0;
         if (c == 8'h0a) begin
            parse_line_end();
            return;
         end
         if (parse_line_char(8'h0d)) return;
      end
      if (c == 8'h0d) p_cr = 1;
      else void'(parse_line_char(c));
   endtask

   task automatic queue_text(string s, bit fresh = 0);
      byte_item_t it;
      for (int i = 0; i < s.len(); i++) begin
         it.rx_byte = s[i];
         it.new_conn = fresh && i == 0;
         pending_bytes.push_back(it);
      end
   endtask

   function automatic string crlf();
      return {8'h0d, 8'h0a};
   endfunction

   function automatic string random_text(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, 8'($urandom_range(0, 255))};
      return s;
   endfunction

   function automatic string pick_blanks();
      string s;
      s = "";
      repeat ($urandom_range(0, 2)) s = {s, ($urandom_range(0, 1) ? " " : 8'h09)};
      return s;
   endfunction

   function automatic string status_line();
      case ($urandom_range(0, 9))
         0: return {"HTTP/1.1 2x0 OK", crlf()};
         1: return {"HTTP/1.1", crlf()};
         2: return {"HTTP/1.1 ", $sformatf("%0d", $urandom_range(0, 99999)), " X", crlf()};
         default: return {"HTTP/1.1 ", $sformatf("%0d", $urandom_range(100, 599)),
                          " OK", crlf()};
      endcase
   endfunction

   // Builds one random, mostly well-formed response.
   task automatic queue_response(bit fresh);
      string s;
      int n;
      bit chunked;
      s = status_line();
      chunked = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) s = {s, "X-Other: a", 8'h0d, "b", crlf()};
      if ($urandom_range(0, 9) == 0) s = {s, "NoColonHere", crlf()};
      if ($urandom_range(0, 9) == 0) s = {s, "content-length: 3", crlf()};
      if ($urandom_range(0, 9) == 0) s = {s, "Content-Length: 1x", crlf()};
      if ($urandom_range(0, 19) == 0) s = {s, "Content-Length: 99999999999", crlf()};
      if ($urandom_range(0, 9) == 0) s = {s, "Transfer-Encoding: chunkedx", crlf()};
      if (chunked)
         s = {s, "Transfer-Encoding:", pick_blanks(), "chunked", pick_blanks(), crlf()};
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      if (!chunked || $urandom_range(0, 3) == 0)
         s = {s, "Content-Length:", pick_blanks(), $sformatf("%0d", n), pick_blanks(), crlf()};
      s = {s, crlf()};
      if (!chunked) begin
         s = {s, random_text(n)};
      end else begin
         repeat ($urandom_range(0, 3)) begin
            n = $urandom_range(1, 10);
            s = {s, ($urandom_range(0, 1) ? $sformatf("%x", n) : $sformatf("%X", n))};
            if ($urandom_range(0, 3) == 0) s = {s, " ;ext=1"};
            s = {s, crlf(), random_text(n)};
            s = {s, ($urandom_range(0, 19) == 0) ? "x\n" : crlf()};
         end
         if ($urandom_range(0, 19) == 0) s = {s, "fffffffff", crlf()};
         if ($urandom_range(0, 19) == 0) s = {s, "g", crlf()};
         s = {s, "0", crlf()};
         if ($urandom_range(0, 2) == 0) s = {s, "Trailer: v", crlf()};
         s = {s, crlf()};
      end
      queue_text(s, fresh);
   endtask

   always @(posedge clock) begin
      byte_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte({req_rx_byte, req_new_connection});
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               it = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_rx_byte <= it.rx_byte;
               req_new_connection <= it.new_conn;
            end else begin
               req_valid <= 1'b0;
               req_rx_byte <= 8'($urandom);
               req_new_connection <= 1'($urandom);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type got, exp;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_body_byte, rsp_response_end, rsp_status_code,
                 rsp_was_chunked, rsp_error_code};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            error_count++;
         end else begin
            exp = expected_results.pop_front();
            if (got !== exp) begin
               $display("%0t: mismatch expected %p actual %p", $time, exp, got);
               error_count++;
            end
         end
      end
   end

   initial begin
      clear_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      queue_text({"HTTP/1.1 200 OK", crlf(), "Content-Length: 2", crlf(), crlf(), "hi"});
      queue_text({"HTTP/1.1 204 X", crlf(), crlf()});
      queue_text({"HTTP/1.1 1234 X", crlf(), "Transfer-Encoding: chunked", crlf(),
                  "Content-Length: 5", crlf(), crlf(), "2;a", crlf(), 8'hff, 8'h00, crlf(),
                  "0", crlf(), "T: 1", crlf(), crlf()});
      queue_text({"HTTP/1.1 20 ", 8'h0d, "x", crlf()});
      queue_text({"garbage", crlf()}, 1);
      queue_text({"HTTP/1.1 200 OK", crlf()}, 1);
      queue_text({"Content-Length: 4294967296", crlf()});
      queue_text({"HTTP/1.1 200 OK", crlf(), "Content-Length:", crlf()}, 1);
      queue_text({"HTTP/1.1 200 OK", crlf(), "Transfer-Encoding: chunked", crlf(), crlf(),
                  "100000000", crlf()}, 1);
      queue_text({"HTTP/1.1 200 OK", crlf(), "Transfer-Encoding: chunked", crlf(), crlf(),
                  "1", crlf(), "a", "zz"}, 1);
      queue_text({"HTTP/1.1 200 OK", crlf(), "Content-Length: 4294967295", crlf(), crlf(),
                  "abc"}, 1);
      queue_text({crlf()}, 1);
      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         send_idle_pct = (phase_no == 0) ? 13 : (phase_no == 1) ? 47 : 0;
         recv_idle_pct = (phase_no == 0) ? 47 : (phase_no == 1) ? 13 : 0;
         repeat (7) queue_response($urandom_range(0, 9) == 0);
         if (phase_no == 2) queue_text(random_text(60), 1);
         queue_text("", 0);
         queue_response(1);
         wait (pending_bytes.size() == 0);
      end
      wait (pending_bytes.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end
endmodule

// ===== http_response_deframer_unit.f =====
src/hrd_pkg.sv
src/hrd_front.sv
src/hrd_back.sv
src/http_response_deframer_unit.sv
tb/sv/tb_http_response_deframer_unit.sv
